/* hw/rtl/gibs_pkg.sv */
// ----------------------------------------------------------------------------
// gibs_pkg
// Shared types, widths and helpers for the greedy IoU box suppression block.
// ----------------------------------------------------------------------------
package gibs_pkg;

   localparam int KEPT_DEPTH = 64;
   localparam int ADDR_W     = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
   localparam int CNT_W      = $clog2(KEPT_DEPTH + 1);

   localparam int COORD_W = 16;
   localparam int LEN_W   = 15;
   localparam int SPAN_W  = 18;
   localparam int AREA_W  = 2 * LEN_W;
   localparam int UNION_W = AREA_W + 1;
   localparam int THR_W   = 16;
   localparam int PROD_W  = THR_W + UNION_W;
   localparam int POS_W   = 16;

   localparam int ENTRY_W = AREA_W + 2 * LEN_W + 2 * COORD_W;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd29491;

   // number of stages from memory read to suppress flag
   localparam int PIPE_N = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } gibs_state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } gibs_cmd_type;

   typedef struct packed {
      logic scan_more;
      logic pipe_busy;
      logic out_free;
   } gibs_status_type;

   // length of the overlap of two intervals, zero if they only touch or miss
   function automatic logic [LEN_W-1:0] span_overlap(
      input logic [COORD_W-1:0] a_lo,
      input logic [LEN_W-1:0]   a_len,
      input logic [COORD_W-1:0] b_lo,
      input logic [LEN_W-1:0]   b_len
   );
      logic signed [SPAN_W-1:0] a0;
      logic signed [SPAN_W-1:0] a1;
      logic signed [SPAN_W-1:0] b0;
      logic signed [SPAN_W-1:0] b1;
      logic signed [SPAN_W-1:0] lo;
      logic signed [SPAN_W-1:0] hi;
      logic signed [SPAN_W-1:0] d;
      a0 = {{(SPAN_W-COORD_W){a_lo[COORD_W-1]}}, a_lo};
      b0 = {{(SPAN_W-COORD_W){b_lo[COORD_W-1]}}, b_lo};
      a1 = a0 + $signed({{(SPAN_W-LEN_W){1'b0}}, a_len});
      b1 = b0 + $signed({{(SPAN_W-LEN_W){1'b0}}, b_len});
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      d  = hi - lo;
      return (d > $signed(SPAN_W'(0))) ? d[LEN_W-1:0] : '0;
   endfunction

endpackage

/* hw/rtl/greedy_iou_box_suppression.sv */
// ----------------------------------------------------------------------------
// greedy_iou_box_suppression
// Greedy IoU suppression of score-ordered boxes against a kept-box table.
// ----------------------------------------------------------------------------
// One box is in work at a time. The kept table is one memory with a single
// read port, so the sweep reads one kept box a cycle. A five-stage overlap and
// threshold pipeline follows and drains before the decision. The next box is
// accepted in the cycle that the result word appears. A finished word waits in
// the output register while the next box is accepted. If that word is still
// stalled when the next decision is ready, the box holds in its last cycle
// until the receiver takes the word. No clearing pass follows reset; the
// threshold resets to 29491 (about 0.45).
module greedy_iou_box_suppression (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [gibs_pkg::THR_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_first,
   input  logic signed [gibs_pkg::COORD_W-1:0]  req_left_x,
   input  logic signed [gibs_pkg::COORD_W-1:0]  req_top_y,
   input  logic [gibs_pkg::LEN_W-1:0]           req_box_width,
   input  logic [gibs_pkg::LEN_W-1:0]           req_box_height,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_keep,
   output logic [gibs_pkg::POS_W-1:0]           rsp_box_index,
   output logic                                 rsp_table_full
);

   logic [gibs_pkg::THR_W-1:0] threshold_ff;
   gibs_pkg::gibs_cmd_type     cmd;
   gibs_pkg::gibs_status_type  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= gibs_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   gibs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gibs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .threshold      (threshold_ff),
      .req_first      (req_first),
      .req_left_x     (req_left_x),
      .req_top_y      (req_top_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_keep       (rsp_keep),
      .rsp_box_index  (rsp_box_index),
      .rsp_table_full (rsp_table_full)
   );

endmodule

/* hw/rtl/gibs_ctrl.sv */
// ----------------------------------------------------------------------------
// gibs_ctrl
// Sequencer: accepts a word, sweeps the kept table, drains, commits result.
// ----------------------------------------------------------------------------
module gibs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  gibs_pkg::gibs_status_type status,
   output gibs_pkg::gibs_cmd_type    cmd
);

   gibs_pkg::gibs_state_type state_ff;
   gibs_pkg::gibs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gibs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gibs_pkg::ST_IDLE: begin
            if (req_valid) state_in = gibs_pkg::ST_SCAN;
         end
         gibs_pkg::ST_SCAN: begin
            if (!status.scan_more) state_in = gibs_pkg::ST_DRAIN;
         end
         gibs_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) state_in = gibs_pkg::ST_FINISH;
         end
         gibs_pkg::ST_FINISH: begin
            if (status.out_free) state_in = gibs_pkg::ST_IDLE;
         end
         default: state_in = gibs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      unique case (state_ff)
         gibs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         gibs_pkg::ST_SCAN: begin
            cmd.issue = status.scan_more;
         end
         gibs_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         gibs_pkg::ST_FINISH: begin
            cmd.commit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* hw/rtl/gibs_dp.sv */
// ----------------------------------------------------------------------------
// gibs_dp
// Datapath: kept-box memory, overlap pipeline, counters and result register.
// ----------------------------------------------------------------------------
module gibs_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gibs_pkg::gibs_cmd_type                cmd,
   output gibs_pkg::gibs_status_type             status,
   input  logic [gibs_pkg::THR_W-1:0]           threshold,
   input  logic                                 req_first,
   input  logic signed [gibs_pkg::COORD_W-1:0]  req_left_x,
   input  logic signed [gibs_pkg::COORD_W-1:0]  req_top_y,
   input  logic [gibs_pkg::LEN_W-1:0]           req_box_width,
   input  logic [gibs_pkg::LEN_W-1:0]           req_box_height,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_keep,
   output logic [gibs_pkg::POS_W-1:0]           rsp_box_index,
   output logic                                 rsp_table_full
);

   // current box
   logic [gibs_pkg::COORD_W-1:0] box_x_ff;
   logic [gibs_pkg::COORD_W-1:0] box_y_ff;
   logic [gibs_pkg::LEN_W-1:0]   box_w_ff;
   logic [gibs_pkg::LEN_W-1:0]   box_h_ff;
   logic [gibs_pkg::AREA_W-1:0]  area_a_ff;

   // set state
   logic [gibs_pkg::CNT_W-1:0]   count_ff;
   logic [gibs_pkg::CNT_W-1:0]   count_in;
   logic [gibs_pkg::POS_W-1:0]   pos_ff;
   logic [gibs_pkg::POS_W-1:0]   pos_in;
   logic [gibs_pkg::CNT_W-1:0]   scan_ff;
   logic                         supp_ff;

   // memory
   logic [gibs_pkg::ENTRY_W-1:0] kept_mem [gibs_pkg::KEPT_DEPTH];
   logic [gibs_pkg::ENTRY_W-1:0] rd_ff;
   logic [gibs_pkg::ENTRY_W-1:0] wr_entry;
   logic                         wr_en;

   // pipeline
   logic [gibs_pkg::PIPE_N-1:0]  pipe_v_ff;
   logic [gibs_pkg::LEN_W-1:0]   dx_ff;
   logic [gibs_pkg::LEN_W-1:0]   dy_ff;
   logic [gibs_pkg::AREA_W-1:0]  areab1_ff;
   logic [gibs_pkg::AREA_W-1:0]  areab2_ff;
   logic [gibs_pkg::AREA_W-1:0]  inter2_ff;
   logic [gibs_pkg::AREA_W-1:0]  inter3_ff;
   logic [gibs_pkg::AREA_W-1:0]  inter4_ff;
   logic [gibs_pkg::UNION_W-1:0] union3_ff;
   logic                         unz4_ff;
   logic [gibs_pkg::PROD_W-1:0]  prod4_ff;

   logic [gibs_pkg::LEN_W-1:0]   dx_in;
   logic [gibs_pkg::LEN_W-1:0]   dy_in;
   logic [gibs_pkg::AREA_W-1:0]  inter_in;
   logic [gibs_pkg::UNION_W-1:0] union_in;
   logic [gibs_pkg::PROD_W-1:0]  prod_in;
   logic                         supp_hit;

   // result word
   logic                         rsp_valid_ff;
   logic                         rsp_keep_ff;
   logic [gibs_pkg::POS_W-1:0]   rsp_index_ff;
   logic                         rsp_full_ff;

   logic                         keep;
   logic                         room;

   assign keep  = !supp_ff;
   assign room  = count_ff < gibs_pkg::CNT_W'(gibs_pkg::KEPT_DEPTH);
   assign wr_en = cmd.commit && keep && room;
   assign wr_entry = {area_a_ff, box_h_ff, box_w_ff, box_y_ff, box_x_ff};

   assign status.scan_more = scan_ff < count_ff;
   assign status.pipe_busy = |pipe_v_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // box latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         box_x_ff <= req_left_x;
         box_y_ff <= req_top_y;
         box_w_ff <= req_box_width;
         box_h_ff <= req_box_height;
      end
      area_a_ff <= gibs_pkg::AREA_W'(box_w_ff) * gibs_pkg::AREA_W'(box_h_ff);
   end

   // counters
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (cmd.load && req_first) begin
         count_in = '0;
         pos_in   = '0;
      end else if (cmd.commit) begin
         if (wr_en) count_in = count_ff + gibs_pkg::CNT_W'(1);
         if (pos_ff != '1) pos_in = pos_ff + gibs_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         scan_ff  <= '0;
         supp_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         if (cmd.load) begin
            scan_ff <= '0;
         end else if (cmd.issue) begin
            scan_ff <= scan_ff + gibs_pkg::CNT_W'(1);
         end
         if (cmd.load) begin
            supp_ff <= 1'b0;
         end else if (supp_hit) begin
            supp_ff <= 1'b1;
         end
      end
   end

   // kept table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         kept_mem[count_ff[gibs_pkg::ADDR_W-1:0]] <= wr_entry;
      end
      rd_ff <= kept_mem[scan_ff[gibs_pkg::ADDR_W-1:0]];
   end

   // overlap pipeline
   assign dx_in = gibs_pkg::span_overlap(box_x_ff, box_w_ff, rd_ff[15:0], rd_ff[46:32]);
   assign dy_in = gibs_pkg::span_overlap(box_y_ff, box_h_ff, rd_ff[31:16], rd_ff[61:47]);
   assign inter_in = gibs_pkg::AREA_W'(dx_ff) * gibs_pkg::AREA_W'(dy_ff);
   assign union_in = gibs_pkg::UNION_W'(area_a_ff) + gibs_pkg::UNION_W'(areab2_ff)
                   - gibs_pkg::UNION_W'(inter2_ff);
   assign prod_in  = gibs_pkg::PROD_W'(threshold) * gibs_pkg::PROD_W'(union3_ff);
   assign supp_hit = pipe_v_ff[gibs_pkg::PIPE_N-1] && unz4_ff
                   && ({1'b0, inter4_ff, 16'h0000} > prod4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else begin
         pipe_v_ff <= {pipe_v_ff[gibs_pkg::PIPE_N-2:0], cmd.issue};
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      areab1_ff <= rd_ff[gibs_pkg::ENTRY_W-1 -: gibs_pkg::AREA_W];
      inter2_ff <= inter_in;
      areab2_ff <= areab1_ff;
      union3_ff <= union_in;
      inter3_ff <= inter2_ff;
      prod4_ff  <= prod_in;
      inter4_ff <= inter3_ff;
      unz4_ff   <= union3_ff != '0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_keep_ff  <= keep;
         rsp_index_ff <= pos_ff;
         rsp_full_ff  <= keep && !room;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = rsp_keep_ff;
   assign rsp_box_index  = rsp_index_ff;
   assign rsp_table_full = rsp_full_ff;

   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(|pipe_v_ff))
      else $error("commit while overlap pipeline busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gibs_pkg::CNT_W'(gibs_pkg::KEPT_DEPTH))
      else $error("kept count beyond table depth");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> scan_ff < count_ff)
      else $error("read issued past kept count");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && !rsp_keep_ff))
      else $error("table full flagged on suppressed box");

endmodule

/* tb/tb_greedy_iou_box_suppression.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_iou_box_suppression
// Drives sets of score-ordered boxes into the suppression block under a range
// of IoU thresholds. A local copy of the kept list judges every accepted box,
// and each result word is checked against the oldest pending verdict. The
// sender works in bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_greedy_iou_box_suppression;

   localparam int          PHASE_ITEMS  = 105;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          SETTLE_CYCLES = 120;
   localparam int          INDEX_CAP    = 65535;

   typedef struct packed {
      logic                         first;
      logic [gibs_pkg::COORD_W-1:0] left_x;
      logic [gibs_pkg::COORD_W-1:0] top_y;
      logic [gibs_pkg::LEN_W-1:0]   box_width;
      logic [gibs_pkg::LEN_W-1:0]   box_height;
   } box_word_type;

   typedef struct packed {
      logic                       keep;
      logic [gibs_pkg::POS_W-1:0] box_index;
      logic                       table_full;
   } verdict_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_pattern_type;

   typedef enum int {
      SET_CLUSTER,
      SET_GRID,
      SET_DEGENERATE,
      SET_NOISE
   } set_kind_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [gibs_pkg::THR_W-1:0]          csr_write_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_first = 1'b0;
   logic signed [gibs_pkg::COORD_W-1:0] req_left_x = '0;
   logic signed [gibs_pkg::COORD_W-1:0] req_top_y = '0;
   logic [gibs_pkg::LEN_W-1:0]          req_box_width = '0;
   logic [gibs_pkg::LEN_W-1:0]          req_box_height = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_keep;
   logic [gibs_pkg::POS_W-1:0]          rsp_box_index;
   logic                                rsp_table_full;

   greedy_iou_box_suppression DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first        (req_first),
      .req_left_x       (req_left_x),
      .req_top_y        (req_top_y),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_keep         (rsp_keep),
      .rsp_box_index    (rsp_box_index),
      .rsp_table_full   (rsp_table_full)
   );

   // boxes waiting to be sent and verdicts waiting for their result word
   box_word_type   pending_boxes[$];
   verdict_type    expected_verdicts[$];

   // local copy of the suppression state
   box_word_type   held_boxes[gibs_pkg::KEPT_DEPTH];
   longint         held_areas[gibs_pkg::KEPT_DEPTH];
   int             held_count;
   int             set_index;
   logic [gibs_pkg::THR_W-1:0] iou_threshold;

   box_word_type   staged_box;
   logic           word_taken = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   stall_pattern_type stall_pattern = STALL_NONE;
   int             pattern_left = 0;
   int             fail_count = 0;
   int unsigned    cycle_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint max_of(input longint a, input longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic longint min_of(input longint a, input longint b);
      return (a < b) ? a : b;
   endfunction

   // greedy suppression of one box against the held list
   function automatic verdict_type judge_box(input box_word_type b);
      verdict_type v;
      longint   ax, ay, aw, ah, area_a;
      longint   bx, by, bw, bh;
      longint   x0, y0, x1, y1, inter, uni;
      bit       survives;
      survives = 1'b1;
      if (b.first) begin
         held_count = 0;
         set_index = 0;
      end
      ax = longint'($signed(b.left_x));
      ay = longint'($signed(b.top_y));
      aw = longint'(b.box_width);
      ah = longint'(b.box_height);
      area_a = aw * ah;
      for (int i = 0; i < held_count; i++) begin
         bx = longint'($signed(held_boxes[i].left_x));
         by = longint'($signed(held_boxes[i].top_y));
         bw = longint'(held_boxes[i].box_width);
         bh = longint'(held_boxes[i].box_height);
         x0 = max_of(ax, bx);
         y0 = max_of(ay, by);
         x1 = min_of(ax + aw, bx + bw);
         y1 = min_of(ay + ah, by + bh);
         inter = (x1 <= x0 || y1 <= y0) ? 0 : (x1 - x0) * (y1 - y0);
         uni = area_a + held_areas[i] - inter;
         if (uni > 0 && inter * 65536 > longint'(iou_threshold) * uni)
            survives = 1'b0;
      end
      v.keep = survives;
      v.table_full = 1'b0;
      if (survives) begin
         if (held_count < gibs_pkg::KEPT_DEPTH) begin
            held_boxes[held_count] = b;
            held_areas[held_count] = area_a;
            held_count++;
         end else begin
            v.table_full = 1'b1;
         end
      end
      v.box_index = set_index[gibs_pkg::POS_W-1:0];
      if (set_index < INDEX_CAP)
         set_index++;
      return v;
   endfunction

   function automatic int fit_coord(input int v);
      return (v < -32768) ? -32768 : (v > 32767) ? 32767 : v;
   endfunction

   function automatic int fit_len(input int v);
      return (v < 0) ? 0 : (v > 32767) ? 32767 : v;
   endfunction

   task automatic add_box(input bit f, input int x, input int y, input int w, input int h);
      box_word_type b;
      b.first = f;
      b.left_x = x[gibs_pkg::COORD_W-1:0];
      b.top_y = y[gibs_pkg::COORD_W-1:0];
      b.box_width = w[gibs_pkg::LEN_W-1:0];
      b.box_height = h[gibs_pkg::LEN_W-1:0];
      pending_boxes.insert(pending_boxes.size(), b);
   endtask

   task automatic add_random_set(input set_kind_type kind, output int added);
      int cx, cy, bw, bh, n, x, y, w, h;
      cx = int'($urandom_range(40000)) - 20000;
      cy = int'($urandom_range(40000)) - 20000;
      bw = $urandom_range(16, 3000);
      bh = $urandom_range(16, 3000);
      x = cx;
      y = cy;
      w = bw;
      h = bh;
      case (kind)
         SET_CLUSTER: begin
            n = $urandom_range(3, 16);
            for (int k = 0; k < n; k++) begin
               x = fit_coord(cx + int'($urandom_range(bw / 2)) - bw / 4);
               y = fit_coord(cy + int'($urandom_range(bh / 2)) - bh / 4);
               w = fit_len(bw + int'($urandom_range(bw / 2)) - bw / 4);
               h = fit_len(bh + int'($urandom_range(bh / 2)) - bh / 4);
               add_box(k == 0, x, y, w, h);
            end
         end
         SET_GRID: begin
            n = $urandom_range(66, 72);
            for (int k = 0; k < n; k++) begin
               // now and then repeat the previous box so it is suppressed if that box was stored
               if (k == 0 || $urandom_range(7) != 0) begin
                  x = -30000 + (k % 16) * 3500;
                  y = -30000 + (k / 16) * 3500;
                  w = $urandom_range(500, 3000);
                  h = $urandom_range(500, 3000);
               end
               add_box(k == 0, x, y, w, h);
            end
         end
         SET_DEGENERATE: begin
            n = $urandom_range(3, 8);
            for (int k = 0; k < n; k++) begin
               case ($urandom_range(3))
                  0: add_box(k == 0, cx, cy, 0, bh);
                  1: add_box(k == 0, cx, cy, bw, 0);
                  2: add_box(k == 0, cx, cy, 0, 0);
                  default: add_box(k == 0, cx, cy, bw, bh);
               endcase
            end
         end
         default: begin
            n = $urandom_range(2, 10);
            for (int k = 0; k < n; k++)
               add_box($urandom_range(7) == 0, $urandom, $urandom, $urandom, $urandom);
         end
      endcase
      added = n;
   endtask

   task automatic wait_drained();
      while (pending_boxes.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_threshold(input logic [gibs_pkg::THR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sender: bursts of words with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (req_valid && !word_taken) begin
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_boxes.size() != 0) begin
         staged_box = pending_boxes.pop_front();
         req_valid <= 1'b1;
         req_first <= staged_box.first;
         req_left_x <= staged_box.left_x;
         req_top_y <= staged_box.top_y;
         req_box_width <= staged_box.box_width;
         req_box_height <= staged_box.box_height;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall pattern is drawn anew each time its run ends
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern <= stall_pattern_type'($urandom_range(3));
            pattern_left <= $urandom_range(50, 300);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_pattern)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(3) != 0);
            default:     rsp_stall <= ($urandom_range(15) == 0) ? ~rsp_stall : rsp_stall;
         endcase
      end
   end

   // accepted boxes are judged here, result words checked against the verdicts
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
         held_count = 0;
         set_index = 0;
         iou_threshold = gibs_pkg::THRESHOLD_RESET;
      end else begin
         word_taken <= req_valid && !req_stall;
         if (csr_write_enable)
            iou_threshold = csr_write_data;
         if (req_valid && !req_stall)
            expected_verdicts.insert(expected_verdicts.size(),
                                     judge_box({req_first, req_left_x, req_top_y,
                                                req_box_width, req_box_height}));
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: word with no box pending: keep %0b index %0d full %0b",
                           $time, rsp_keep, rsp_box_index, rsp_table_full);
            end else begin
               if (rsp_keep !== expected_verdicts[0].keep
                   || rsp_box_index !== expected_verdicts[0].box_index
                   || rsp_table_full !== expected_verdicts[0].table_full) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected keep %0b index %0d full %0b, got %0b %0d %0b",
                              $time, expected_verdicts[0].keep, expected_verdicts[0].box_index,
                              expected_verdicts[0].table_full, rsp_keep, rsp_box_index,
                              rsp_table_full);
               end
               void'(expected_verdicts.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** greedy_iou_box_suppression: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [gibs_pkg::THR_W-1:0] thr_plan [8];
      int added, total;
      thr_plan[0] = 16'd0;
      thr_plan[1] = 16'd65535;
      thr_plan[2] = 16'd32768;
      thr_plan[3] = gibs_pkg::THR_W'($urandom);
      thr_plan[4] = 16'd1;
      thr_plan[5] = gibs_pkg::THR_W'($urandom);
      thr_plan[6] = gibs_pkg::THRESHOLD_RESET;
      thr_plan[7] = gibs_pkg::THR_W'($urandom);

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed boxes at the reset threshold
      add_box(1, 0, 0, 160, 160);
      add_box(0, 0, 0, 160, 160);
      add_box(0, 160, 0, 160, 160);
      add_box(0, 0, 160, 160, 160);
      add_box(0, 5000, 5000, 320, 320);
      add_box(0, 10000, 10000, 0, 160);
      add_box(0, 10000, 10000, 0, 160);
      add_box(0, 12000, 12000, 160, 0);
      add_box(0, -32768, -32768, 32767, 32767);
      add_box(0, 32767, 32767, 32767, 32767);
      add_box(0, 80, 0, 160, 160);
      add_box(0, 16, 0, 160, 160);
      add_box(0, 6000, 6000, 1, 1);
      add_box(1, 0, 0, 160, 160);
      add_box(0, 0, 0, 160, 160);
      add_box(0, -32768, 32767, 0, 32767);
      add_box(0, 32767, -32768, 32767, 0);
      add_box(1, 0, 0, 0, 0);
      add_box(0, 0, 0, 0, 0);
      add_box(0, 0, 0, 32767, 32767);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         set_threshold(thr_plan[p]);
         total = 0;
         if (p % 2 == 0) begin
            add_random_set(SET_GRID, added);
            total += added;
         end
         while (total < PHASE_ITEMS) begin
            case ($urandom_range(19))
               0, 1, 2:    add_random_set(SET_DEGENERATE, added);
               3, 4, 5, 6: add_random_set(SET_NOISE, added);
               default:    add_random_set(SET_CLUSTER, added);
            endcase
            total += added;
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** greedy_iou_box_suppression: PASSED **");
      end else begin
         $display("** greedy_iou_box_suppression: FAILED **");
      end
      $finish;
   end

endmodule
